@@ hw/rtl/pfc_pkg.sv @@
`default_nettype none

package pfc_pkg;

	// longest path accepted before the overlong flag sets
	localparam int unsigned MAX_PATH = 256;

	// position counters saturate just past MAX_PATH, one spare code for the +1 of leaf start
	localparam int unsigned POS_W = $clog2(MAX_PATH + 3);
	localparam int unsigned LEN_W = 9;
	localparam int unsigned CNT_W = (POS_W > LEN_W) ? POS_W : LEN_W;
	localparam int unsigned OFS_W = 8;

	localparam logic [31:0] HASH_BASIS = 32'd2166136261;
	localparam logic [31:0] HASH_PRIME = 32'd16777619;

	localparam logic [3:0] SUFFIX_LIMIT = 4'd15;
	localparam int unsigned SUFFIX_KEEP = 4;

	// "smb_" + 8 hex digits + "."
	localparam logic [4:0] HASHED_BASE = 5'd13;

	localparam logic [7:0] CHAR_LOW = 8'h20;
	localparam logic [7:0] CHAR_HIGH = 8'h7E;
	localparam logic [7:0] CHAR_SLASH = 8'h2F;
	localparam logic [7:0] CHAR_DOT = 8'h2E;

	typedef enum logic [1:0] {
		VERDICT_REJECT = 2'd0,
		VERDICT_KEEP = 2'd1,
		VERDICT_HASHED = 2'd2
	} verdict_t;

	localparam logic [1:0] KIND_JPG = 2'd0;
	localparam logic [1:0] KIND_JPEG = 2'd1;
	localparam logic [1:0] KIND_PNG = 2'd2;
	localparam logic [1:0] KIND_BMP = 2'd3;

	typedef logic [SUFFIX_KEEP-1:0][7:0] suffix_t;

	typedef struct packed {
		logic [31:0] hash;
		logic [CNT_W-1:0] pos;
		logic [OFS_W-1:0] leaf_start;
		logic [CNT_W-1:0] leaf_count;
		logic leading_dot;
		logic dot_seen;
		logic [3:0] suffix_count;
		logic unclean;
		logic overlong;
	} leaf_info_t;

endpackage

`default_nettype wire

@@ hw/rtl/pfc_scan.sv @@
`default_nettype none

module pfc_scan (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic step,
	input wire logic [7:0] byte_in,
	input wire logic last,
	output pfc_pkg::leaf_info_t upd,
	output pfc_pkg::suffix_t suffix_upd
);
	import pfc_pkg::*;

	leaf_info_t state_q;
	suffix_t suffix_q;
	logic [31:0] mixed;
	logic [7:0] lower;
	logic [CNT_W-1:0] start_wide;
	logic bad_char;

	always_comb begin
		lower = ((byte_in >= 8'h41) && (byte_in <= 8'h5A)) ? (byte_in + 8'd32) : byte_in;
		bad_char = (byte_in < CHAR_LOW) || (byte_in > CHAR_HIGH) ||
			(byte_in == 8'h5C) || (byte_in == 8'h3A) || (byte_in == 8'h2A) ||
			(byte_in == 8'h3F) || (byte_in == 8'h22) || (byte_in == 8'h3C) ||
			(byte_in == 8'h3E) || (byte_in == 8'h7C);
		mixed = state_q.hash ^ {24'd0, byte_in};
		start_wide = state_q.pos + CNT_W'(1);

		upd = state_q;
		suffix_upd = suffix_q;
		upd.hash = mixed * HASH_PRIME;

		if (byte_in == CHAR_SLASH) begin
			upd.leaf_count = '0;
			upd.leading_dot = 1'b0;
			upd.dot_seen = 1'b0;
			upd.suffix_count = '0;
			upd.unclean = 1'b0;
			upd.leaf_start = (start_wide > CNT_W'(255)) ? 8'd255 : start_wide[OFS_W-1:0];
		end else begin
			if (byte_in == CHAR_DOT) begin
				if (state_q.leaf_count == '0) begin
					upd.leading_dot = 1'b1;
				end
				upd.dot_seen = 1'b1;
				upd.suffix_count = '0;
			end else if (state_q.dot_seen) begin
				if (state_q.suffix_count < 4'(SUFFIX_KEEP)) begin
					suffix_upd[state_q.suffix_count[1:0]] = lower;
				end
				if (state_q.suffix_count < SUFFIX_LIMIT) begin
					upd.suffix_count = state_q.suffix_count + 4'd1;
				end
			end
			if (bad_char) begin
				upd.unclean = 1'b1;
			end
			if (state_q.leaf_count <= CNT_W'(MAX_PATH)) begin
				upd.leaf_count = state_q.leaf_count + CNT_W'(1);
			end
		end

		if (state_q.pos <= CNT_W'(MAX_PATH)) begin
			upd.pos = state_q.pos + CNT_W'(1);
		end
		if (upd.pos > CNT_W'(MAX_PATH)) begin
			upd.overlong = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= '{hash: HASH_BASIS, default: '0};
		end else if (step) begin
			if (last) begin
				state_q <= '{hash: HASH_BASIS, default: '0};
			end else begin
				state_q <= upd;
			end
		end
	end

	// only entries below the suffix count are ever looked at
	always_ff @(posedge clk) begin
		if (step) begin
			suffix_q <= suffix_upd;
		end
	end

endmodule

`default_nettype wire

@@ hw/rtl/pfc_judge.sv @@
`default_nettype none

module pfc_judge (
	input wire pfc_pkg::leaf_info_t info,
	input wire pfc_pkg::suffix_t suffix,
	input wire logic [7:0] capacity,
	output pfc_pkg::verdict_t verdict,
	output logic [1:0] kind
);
	import pfc_pkg::*;

	logic name_ok;
	logic known;
	logic [1:0] match_kind;
	logic [4:0] hashed_len;

	always_comb begin
		name_ok = !info.overlong && (info.leaf_count != '0) && !info.leading_dot &&
			info.dot_seen && (info.suffix_count != '0);
		known = 1'b0;
		match_kind = KIND_JPG;
		if (info.suffix_count == 4'd3) begin
			if (suffix[0] == 8'h6A && suffix[1] == 8'h70 && suffix[2] == 8'h67) begin
				known = 1'b1;
				match_kind = KIND_JPG;
			end else if (suffix[0] == 8'h70 && suffix[1] == 8'h6E && suffix[2] == 8'h67) begin
				known = 1'b1;
				match_kind = KIND_PNG;
			end else if (suffix[0] == 8'h62 && suffix[1] == 8'h6D && suffix[2] == 8'h70) begin
				known = 1'b1;
				match_kind = KIND_BMP;
			end
		end else if (info.suffix_count == 4'd4) begin
			if (suffix[0] == 8'h6A && suffix[1] == 8'h70 && suffix[2] == 8'h65 &&
					suffix[3] == 8'h67) begin
				known = 1'b1;
				match_kind = KIND_JPEG;
			end
		end
		hashed_len = HASHED_BASE + {1'b0, info.suffix_count};

		verdict = VERDICT_REJECT;
		kind = KIND_JPG;
		if (name_ok && known) begin
			if ((info.leaf_count < CNT_W'(capacity)) && !info.unclean) begin
				verdict = VERDICT_KEEP;
				kind = match_kind;
			end else if (8'(hashed_len) < capacity) begin
				verdict = VERDICT_HASHED;
				kind = match_kind;
			end
		end
	end

endmodule

`default_nettype wire

@@ hw/rtl/photo_filename_classifier_unit.sv @@
`default_nettype none

// photo file name classifier: path bytes come in one per transfer, the final byte
// flagged by last_byte. the block hashes the whole path (32-bit fnv-1a) and follows
// the leaf after the last slash; for each flagged byte it hands out one result
// with the verdict (reject, keep leaf verbatim, or use smb_XXXXXXXX.ext), the
// extension kind, the hash, and the leaf offset and length. no characters are
// copied. rate is one byte per clock while no closing byte waits behind a held
// result; the result of a path passes the input register, then the result register.
// the per-byte state loop (hash xor and constant multiply, leaf counters) sets that
// rate. a finished result waiting on result_stall does not block plain path bytes;
// only the next last byte waits behind it. name_capacity is written through the
// cfg channel (always ready); the user must write it only while no path is in
// flight, as the block itself does not enforce this. it resets to 64.
module photo_filename_classifier_unit (
	input wire logic clk,
	input wire logic arst_n,
	// path byte channel
	input wire logic path_valid,
	output logic path_stall,
	input wire logic [7:0] path_byte,
	input wire logic last_byte,
	// result channel
	output logic result_valid,
	input wire logic result_stall,
	output logic [1:0] verdict,
	output logic [1:0] extension_kind,
	output logic [31:0] path_hash,
	output logic [7:0] leaf_offset,
	output logic [8:0] leaf_length,
	// name capacity register write
	input wire logic cfg_valid,
	output logic cfg_ready,
	input wire logic [7:0] cfg_data
);
	import pfc_pkg::*;

	logic [7:0] name_capacity_q;

	// input register
	logic valid_s1;
	logic [7:0] byte_s1;
	logic last_s1;

	// result register
	logic result_valid_q;
	verdict_t verdict_q;
	logic [1:0] kind_q;
	logic [31:0] hash_q;
	logic [7:0] offset_q;
	logic [8:0] length_q;

	logic accept;
	logic step;
	leaf_info_t upd;
	suffix_t suffix_upd;
	verdict_t verdict_c;
	logic [1:0] kind_c;

	// a byte in the input register moves on unless it closes a path and the
	// result register is still held by the consumer
	assign step = valid_s1 && !(last_s1 && result_valid_q && result_stall);
	assign path_stall = valid_s1 && !step;
	assign accept = path_valid && !path_stall;
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			name_capacity_q <= 8'd64;
		end else if (cfg_valid) begin
			name_capacity_q <= cfg_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (step) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			byte_s1 <= path_byte;
			last_s1 <= last_byte;
		end
	end

	// running path and leaf state
	pfc_scan u_scan (
		.clk(clk),
		.arst_n(arst_n),
		.step(step),
		.byte_in(byte_s1),
		.last(last_s1),
		.upd(upd),
		.suffix_upd(suffix_upd)
	);

	// verdict from the state as it stands after the closing byte
	pfc_judge u_judge (
		.info(upd),
		.suffix(suffix_upd),
		.capacity(name_capacity_q),
		.verdict(verdict_c),
		.kind(kind_c)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (step && last_s1) begin
			result_valid_q <= 1'b1;
		end else if (!result_stall) begin
			result_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (step && last_s1) begin
			verdict_q <= verdict_c;
			kind_q <= kind_c;
			hash_q <= upd.hash;
			offset_q <= upd.leaf_start;
			// leaf length saturates at the width of the port
			length_q <= (upd.leaf_count > CNT_W'(511)) ? 9'd511 : upd.leaf_count[8:0];
		end
	end

	assign result_valid = result_valid_q;
	assign verdict = verdict_q;
	assign extension_kind = kind_q;
	assign path_hash = hash_q;
	assign leaf_offset = offset_q;
	assign leaf_length = length_q;

	// the input side only waits behind a held result
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		path_stall |-> (result_valid_q && result_stall && last_s1))
		else $error("path stalled without a held result");

	// a reject carries no extension kind
	a_reject_kind: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid_q && verdict_q == VERDICT_REJECT) |-> (kind_q == KIND_JPG))
		else $error("reject with nonzero extension kind");

	// a verbatim leaf always fits the name buffer
	a_keep_fits: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid_q && verdict_q == VERDICT_KEEP) |->
		(length_q != 9'd0 && length_q < {1'b0, name_capacity_q}))
		else $error("verbatim leaf does not fit");

	// every closing byte that moves on produces a result next cycle
	a_result_follows: assert property (@(posedge clk) disable iff (!arst_n)
		(step && last_s1) |=> result_valid_q)
		else $error("closing byte left no result");

endmodule

`default_nettype wire
